@@ rtl/cfr_pkg.sv @@
// Shared types and constants for the chunked frame reassembly block.
package cfr_pkg;

  localparam int LEN_W     = 17;   // frame length / byte limit width
  localparam int ID_W      = 16;
  localparam int CNT_W     = 16;
  localparam int DROP_W    = 32;
  localparam int PLEN_W    = 10;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int MAX_PAYLOAD = 512;
  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 17'd50000;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_MAX_FRAME_BYTES = 3'd0;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPEND          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORE          = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DONE_END        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE_LAST       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROP_INCOMPLETE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DROP_ORDER      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DROP_OVERFLOW   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_READ            = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     done_frame_id;
    logic [LEN_W-1:0]    frame_bytes;
    logic [CNT_W-1:0]    chunk_count;
    logic [DROP_W-1:0]   drop_count;
  } cfr_result_t;

endpackage

@@ rtl/cfr_ram.sv @@
// Generic single-port RAM with registered read data.
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/chunked_frame_reassembly.sv @@
// Top level of the chunked frame reassembly block.
//
// Input channel (in_valid / in_stall): one transaction per cycle unless
// stalled. A chunk beat carries the chunk header (frame_id, chunk_index,
// chunk_total, payload_len) and one payload byte; a read transaction
// (operation = 1) fetches one byte of the displayed frame at read_address.
// Output channel (out_valid / out_stall): exactly one result transaction per
// input transaction, in order: status, last completed frame id, displayed
// frame length, chunk count, drop count and the byte read (0 otherwise).
// A result passes the RAM read stage, then the output register. Throughput
// is one transaction per cycle when not stalled, set by the single port of
// the frame bank RAM: one payload byte write or one display read each cycle.
// Both ping-pong banks live in one RAM of 2*BANK_BYTES bytes; assembly writes
// the bank that is not displayed, so a completion just flips display_bank.
// A stalled receiver holds the output register; one more transaction can sit
// in the RAM read stage before in_stall rises.
// Reset (rst, synchronous) clears all control state and sets the byte limit
// to 50000; the bank RAM is not cleared, so there is no warm-up pass.
// The max_frame_bytes register sits at APB address 0; write only when idle.
module chunked_frame_reassembly
  import cfr_pkg::*;
#(
  parameter int BANK_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic                header_ok,
  input  logic [ID_W-1:0]     frame_id,
  input  logic [CNT_W-1:0]    chunk_index,
  input  logic [CNT_W-1:0]    chunk_total,
  input  logic [PLEN_W-1:0]   payload_len,
  input  logic [BYTE_W-1:0]   payload_byte,
  input  logic [15:0]         read_address,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     done_frame_id,
  output logic [LEN_W-1:0]    frame_bytes,
  output logic [CNT_W-1:0]    chunk_count,
  output logic [DROP_W-1:0]   drop_count,
  output logic [BYTE_W-1:0]   read_data
);

  localparam int RAM_DEPTH = 2 * BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int LIM_MAX   = (1 << LEN_W) - 1;
  // the limit never exceeds the bank, nor the register range
  localparam logic [LEN_W-1:0] LIMIT_CAP =
    LEN_W'((BANK_BYTES > LIM_MAX) ? LIM_MAX : BANK_BYTES);

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [LEN_W-1:0] max_frame_bytes;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_MAX_FRAME_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_wr) begin
      max_frame_bytes <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr == REG_MAX_FRAME_BYTES) ?
                  {{(PDATA_W-LEN_W){1'b0}}, max_frame_bytes} : '0;

  // ---------------------------------------------------------------------
  // Assembly state
  // ---------------------------------------------------------------------
  logic              display_bank;
  logic [LEN_W-1:0]  assembly_length;
  logic [LEN_W-1:0]  display_length;
  logic [ID_W-1:0]   assembly_frame;
  logic [CNT_W-1:0]  expected_total;
  logic [CNT_W-1:0]  received_chunks;
  logic [DROP_W-1:0] dropped_frames;
  logic [ID_W-1:0]   last_done_frame;
  logic [PLEN_W-1:0] beat_position;
  logic              beat_accept;

  logic              display_bank_next;
  logic [LEN_W-1:0]  assembly_length_next;
  logic [LEN_W-1:0]  display_length_next;
  logic [ID_W-1:0]   assembly_frame_next;
  logic [CNT_W-1:0]  expected_total_next;
  logic [CNT_W-1:0]  received_chunks_next;
  logic [DROP_W-1:0] dropped_frames_next;
  logic [ID_W-1:0]   last_done_frame_next;
  logic [PLEN_W-1:0] beat_position_next;
  logic              beat_accept_next;

  logic [STATUS_W-1:0] st;
  logic [LEN_W-1:0]    byte_limit;
  logic                hdr_bad;
  logic                do_write;
  logic [LEN_W-1:0]    wr_offset;
  logic                rd_hit;
  logic [LEN_W:0]      fit_sum;
  logic                last_beat;
  logic                in_acc;

  // pipeline control
  logic        s1_valid;
  logic        s1_adv;
  cfr_result_t s1_res;
  logic        s1_rd_hit;
  cfr_result_t out_res;
  logic [BYTE_W-1:0] out_rdata;

  // RAM port
  logic              ram_en;
  logic [RAM_AW-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [31:0]       wr_full;
  logic [31:0]       rd_full;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign byte_limit = (max_frame_bytes < LIMIT_CAP) ? max_frame_bytes : LIMIT_CAP;

  assign rd_hit = operation && ({1'b0, read_address} < display_length) &&
                  ({16'b0, read_address} < 32'(BANK_BYTES));

  always_comb begin
    display_bank_next    = display_bank;
    assembly_length_next = assembly_length;
    display_length_next  = display_length;
    assembly_frame_next  = assembly_frame;
    expected_total_next  = expected_total;
    received_chunks_next = received_chunks;
    dropped_frames_next  = dropped_frames;
    last_done_frame_next = last_done_frame;
    beat_position_next   = beat_position;
    beat_accept_next     = beat_accept;
    st        = ST_IGNORE;
    hdr_bad   = 1'b0;
    do_write  = 1'b0;
    wr_offset = assembly_length;
    fit_sum   = '0;
    last_beat = 1'b0;

    if (operation) begin
      st = ST_READ;
    end else begin
      if (beat_position == '0) begin
        beat_accept_next = 1'b0;
        if (!header_ok) begin
          hdr_bad = 1'b1;
        end else if (32'(payload_len) <= MAX_PAYLOAD) begin
          if (chunk_index == '0) begin
            assembly_length_next = '0;
            assembly_frame_next  = frame_id;
            expected_total_next  = chunk_total;
            received_chunks_next = '0;
          end
          fit_sum = {1'b0, assembly_length_next} + (LEN_W+1)'(payload_len);
          if (expected_total_next == '0 || frame_id != assembly_frame_next) begin
            st = ST_IGNORE;
          end else if (chunk_index == chunk_total && payload_len == '0) begin
            if (received_chunks_next >= expected_total_next) begin
              // end marker with every chunk in
              display_bank_next    = ~display_bank;
              display_length_next  = assembly_length_next;
              assembly_length_next = '0;
              last_done_frame_next = assembly_frame_next;
              expected_total_next  = '0;
              received_chunks_next = '0;
              st = ST_DONE_END;
            end else begin
              dropped_frames_next = dropped_frames + 1'b1;
              st = ST_DROP_INCOMPLETE;
            end
          end else if (chunk_index >= expected_total_next) begin
            st = ST_IGNORE;
          end else if (chunk_index != received_chunks_next) begin
            assembly_length_next = '0;
            expected_total_next  = '0;
            received_chunks_next = '0;
            dropped_frames_next  = dropped_frames + 1'b1;
            st = ST_DROP_ORDER;
          end else if (fit_sum > {1'b0, byte_limit}) begin
            assembly_length_next = '0;
            expected_total_next  = '0;
            received_chunks_next = '0;
            dropped_frames_next  = dropped_frames + 1'b1;
            st = ST_DROP_OVERFLOW;
          end else begin
            received_chunks_next = received_chunks_next + 1'b1;
            beat_accept_next     = 1'b1;
            st = ST_APPEND;
          end
        end
      end else begin
        st = beat_accept ? ST_APPEND : ST_IGNORE;
      end

      if (!hdr_bad) begin
        // bytes past the limit are discarded
        if (beat_accept_next && payload_len != '0 && assembly_length_next < byte_limit) begin
          do_write             = 1'b1;
          wr_offset            = assembly_length_next;
          assembly_length_next = assembly_length_next + 1'b1;
        end
        last_beat = (payload_len == '0) ||
                    ({1'b0, beat_position} + 1'b1 >= {1'b0, payload_len});
        if (last_beat) begin
          if (beat_accept_next && received_chunks_next >= expected_total_next) begin
            display_bank_next    = ~display_bank_next;
            display_length_next  = assembly_length_next;
            assembly_length_next = '0;
            last_done_frame_next = assembly_frame_next;
            expected_total_next  = '0;
            received_chunks_next = '0;
            st = ST_DONE_LAST;
          end
          beat_position_next = '0;
          beat_accept_next   = 1'b0;
        end else begin
          beat_position_next = beat_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_bank    <= 1'b0;
      assembly_length <= '0;
      display_length  <= '0;
      assembly_frame  <= '0;
      expected_total  <= '0;
      received_chunks <= '0;
      dropped_frames  <= '0;
      last_done_frame <= '0;
      beat_position   <= '0;
      beat_accept     <= 1'b0;
    end else if (in_acc) begin
      display_bank    <= display_bank_next;
      assembly_length <= assembly_length_next;
      display_length  <= display_length_next;
      assembly_frame  <= assembly_frame_next;
      expected_total  <= expected_total_next;
      received_chunks <= received_chunks_next;
      dropped_frames  <= dropped_frames_next;
      last_done_frame <= last_done_frame_next;
      beat_position   <= beat_position_next;
      beat_accept     <= beat_accept_next;
    end
  end

  // ---------------------------------------------------------------------
  // Frame bank RAM: writes go to the assembly bank, reads to the display bank
  // ---------------------------------------------------------------------
  assign wr_full  = (display_bank ? 32'd0 : 32'(BANK_BYTES)) + 32'(wr_offset);
  assign rd_full  = (display_bank ? 32'(BANK_BYTES) : 32'd0) + {16'b0, read_address};
  assign ram_addr = do_write ? wr_full[RAM_AW-1:0] : rd_full[RAM_AW-1:0];
  assign ram_en   = in_acc && (do_write || rd_hit);

  cfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_bank_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (do_write),
    .addr  (ram_addr),
    .wdata (payload_byte),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Result pipeline: RAM read stage, then output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res.status        <= st;
      s1_res.done_frame_id <= last_done_frame_next;
      s1_res.frame_bytes   <= display_length_next;
      s1_res.chunk_count   <= received_chunks_next;
      s1_res.drop_count    <= dropped_frames_next;
      s1_rd_hit            <= rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res   <= s1_res;
      out_rdata <= s1_rd_hit ? ram_rdata : '0;
    end
  end

  assign status        = out_res.status;
  assign done_frame_id = out_res.done_frame_id;
  assign frame_bytes   = out_res.frame_bytes;
  assign chunk_count   = out_res.chunk_count;
  assign drop_count    = out_res.drop_count;
  assign read_data     = out_rdata;

`ifndef SYNTH
  // payload writes never land in the displayed bank
  a_write_bank: assert property (@(posedge clk) disable iff (rst)
    (ram_en && do_write) |-> ((32'(ram_addr) >= 32'(BANK_BYTES)) == !display_bank))
    else $error("bank write hit displayed bank");

  // a result waiting for the output register is never lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_res) && $stable(ram_rdata)))
    else $error("read stage result lost");

  // drop counter moves by at most one per transaction
  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (dropped_frames == $past(dropped_frames) ||
                     dropped_frames == $past(dropped_frames) + 32'd1))
    else $error("drop counter jumped");

  // only read results carry read data
  a_read_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_READ) |-> (read_data == '0))
    else $error("read data on non-read result");

  // the bank never flips without a completion result for that transaction
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (in_acc && display_bank_next != display_bank) |->
      (st == ST_DONE_END || st == ST_DONE_LAST))
    else $error("bank flip without completion");
`endif

endmodule
